// ===== src/msps_pkg.sv =====
package msps_pkg;

    // Fixed field widths of the result and input channels
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int ORD_W  = 7;

    // Default matrix shape
    localparam int ROWS_DEF = 4;
    localparam int COLS_DEF = 4;

    // Cap on saddle points reported per matrix
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Search sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MIN_RD,
        ST_MIN_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_COL_RD,
        ST_COL_CMP,
        ST_PUSH,
        ST_FINISH
    } state_t;

endpackage

// ===== src/msps_ram.sv =====
module msps_ram #(
    parameter int DEPTH = msps_pkg::ROWS_DEF * msps_pkg::COLS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [msps_pkg::DATA_W-1:0] wr_data,
    input  logic [AW-1:0]                     rd_addr,
    output logic signed [msps_pkg::DATA_W-1:0] rd_data
);

    logic signed [msps_pkg::DATA_W-1:0] mem [DEPTH];

    // Single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/matrix_saddle_point_search.sv =====
// Matrix saddle point search. Elements of a ROWS x COLS signed matrix arrive
// one per transaction in row-major order and are taken one per cycle. After
// the final element the block walks the stored matrix through one memory
// read port and one comparator. Per row it first finds the row minimum and
// then scans the row for it. Each column that holds the minimum gets a column
// check, which stops at the first larger element. Each saddle point found is
// pushed, and a final step closes the report. Both of these wait while the
// output register still holds a result that m_ready has not taken. s_ready
// stays low for the
// whole search. Results come out in row-then-column order with a running
// ordinal; the final one carries m_last_result. A matrix with no saddle point
// gives one result with m_found low, m_last_result high and all other fields
// zero. At most MAX_RESULTS saddle points are reported. A waiting result does
// not block loading of the next matrix.
module matrix_saddle_point_search #(
    parameter int ROWS = msps_pkg::ROWS_DEF,
    parameter int COLS = msps_pkg::COLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [msps_pkg::DATA_W-1:0] s_element_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic [msps_pkg::IDX_W-1:0]         m_row_index,
    output logic [msps_pkg::IDX_W-1:0]         m_col_index,
    output logic signed [msps_pkg::DATA_W-1:0] m_point_value,
    output logic [msps_pkg::ORD_W-1:0]         m_ordinal,
    output logic                               m_last_result
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DW    = msps_pkg::DATA_W;
    localparam int IW    = msps_pkg::IDX_W;
    localparam int OW    = msps_pkg::ORD_W;
    localparam int CW    = msps_pkg::CNT_W;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [IW-1:0] LAST_ROW  = IW'(ROWS - 1);
    localparam logic [IW-1:0] LAST_COL  = IW'(COLS - 1);
    localparam logic [CW-1:0] CNT_MAX   = CW'(msps_pkg::MAX_RESULTS);

    msps_pkg::state_t state_reg, state_next;

    logic [AW-1:0]        load_cnt_reg, load_cnt_next;
    logic [IW-1:0]        row_reg, row_next;
    logic [IW-1:0]        col_reg, col_next;
    logic [IW-1:0]        chk_reg, chk_next;
    logic signed [DW-1:0] rmin_reg, rmin_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    // Held saddle point, waiting until it is known whether it is the last
    logic                 hold_valid_reg, hold_valid_next;
    logic [IW-1:0]        hold_row_reg, hold_row_next;
    logic [IW-1:0]        hold_col_reg, hold_col_next;
    logic signed [DW-1:0] hold_val_reg, hold_val_next;
    logic [OW-1:0]        hold_ord_reg, hold_ord_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [IW-1:0]        out_row_reg, out_row_next;
    logic [IW-1:0]        out_col_reg, out_col_next;
    logic signed [DW-1:0] out_val_reg, out_val_next;
    logic [OW-1:0]        out_ord_reg, out_ord_next;
    logic                 out_last_reg, out_last_next;

    logic                 wr_en;
    logic [AW-1:0]        rd_addr;
    logic signed [DW-1:0] rd_data;
    logic                 slot_free;

    // Where the scan goes after finishing with the current column
    msps_pkg::state_t     adv_state;
    logic [IW-1:0]        adv_row;
    logic [IW-1:0]        adv_col;

    assign s_ready   = (state_reg == msps_pkg::ST_LOAD);
    assign wr_en     = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    msps_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (load_cnt_reg),
        .wr_data (s_element_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read address: row-major cell of (row, col) or (check row, col)
    always_comb begin
        if (state_reg == msps_pkg::ST_COL_RD) begin
            rd_addr = AW'(int'(chk_reg) * COLS + int'(col_reg));
        end else begin
            rd_addr = AW'(int'(row_reg) * COLS + int'(col_reg));
        end
    end

    // Column advance
    always_comb begin
        adv_row = row_reg;
        adv_col = col_reg;
        if (col_reg == LAST_COL) begin
            adv_col = '0;
            if (row_reg == LAST_ROW) begin
                adv_state = msps_pkg::ST_FINISH;
            end else begin
                adv_row   = row_reg + IW'(1);
                adv_state = msps_pkg::ST_MIN_RD;
            end
        end else begin
            adv_col   = col_reg + IW'(1);
            adv_state = msps_pkg::ST_SCAN_RD;
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        load_cnt_next   = load_cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        chk_next        = chk_reg;
        rmin_next       = rmin_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_row_next   = hold_row_reg;
        hold_col_next   = hold_col_reg;
        hold_val_next   = hold_val_reg;
        hold_ord_next   = hold_ord_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_found_next  = out_found_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_val_next    = out_val_reg;
        out_ord_next    = out_ord_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            msps_pkg::ST_LOAD: begin
                if (wr_en) begin
                    if (load_cnt_reg == LAST_CELL) begin
                        load_cnt_next   = '0;
                        row_next        = '0;
                        col_next        = '0;
                        cnt_next        = '0;
                        hold_valid_next = 1'b0;
                        state_next      = msps_pkg::ST_MIN_RD;
                    end else begin
                        load_cnt_next = load_cnt_reg + AW'(1);
                    end
                end
            end
            msps_pkg::ST_MIN_RD: begin
                state_next = msps_pkg::ST_MIN_CMP;
            end
            msps_pkg::ST_MIN_CMP: begin
                if (col_reg == '0 || rd_data < rmin_reg) begin
                    rmin_next = rd_data;
                end
                if (col_reg == LAST_COL) begin
                    col_next   = '0;
                    state_next = msps_pkg::ST_SCAN_RD;
                end else begin
                    col_next   = col_reg + IW'(1);
                    state_next = msps_pkg::ST_MIN_RD;
                end
            end
            msps_pkg::ST_SCAN_RD: begin
                state_next = msps_pkg::ST_SCAN_CMP;
            end
            msps_pkg::ST_SCAN_CMP: begin
                if (rd_data == rmin_reg) begin
                    chk_next   = '0;
                    state_next = msps_pkg::ST_COL_RD;
                end else begin
                    row_next   = adv_row;
                    col_next   = adv_col;
                    state_next = adv_state;
                end
            end
            msps_pkg::ST_COL_RD: begin
                state_next = msps_pkg::ST_COL_CMP;
            end
            msps_pkg::ST_COL_CMP: begin
                if (rd_data > rmin_reg) begin
                    row_next   = adv_row;
                    col_next   = adv_col;
                    state_next = adv_state;
                end else if (chk_reg == LAST_ROW) begin
                    state_next = msps_pkg::ST_PUSH;
                end else begin
                    chk_next   = chk_reg + IW'(1);
                    state_next = msps_pkg::ST_COL_RD;
                end
            end
            msps_pkg::ST_PUSH: begin
                // Move the previous point out, keep the new one held
                if (!hold_valid_reg || slot_free) begin
                    if (hold_valid_reg) begin
                        m_valid_next   = 1'b1;
                        out_found_next = 1'b1;
                        out_row_next   = hold_row_reg;
                        out_col_next   = hold_col_reg;
                        out_val_next   = hold_val_reg;
                        out_ord_next   = hold_ord_reg;
                        out_last_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_row_next   = row_reg;
                    hold_col_next   = col_reg;
                    hold_val_next   = rmin_reg;
                    hold_ord_next   = OW'(cnt_reg) + OW'(1);
                    cnt_next        = cnt_reg + CW'(1);
                    if (cnt_reg + CW'(1) == CNT_MAX) begin
                        state_next = msps_pkg::ST_FINISH;
                    end else begin
                        row_next   = adv_row;
                        col_next   = adv_col;
                        state_next = adv_state;
                    end
                end
            end
            msps_pkg::ST_FINISH: begin
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    out_last_next = 1'b1;
                    if (hold_valid_reg) begin
                        out_found_next = 1'b1;
                        out_row_next   = hold_row_reg;
                        out_col_next   = hold_col_reg;
                        out_val_next   = hold_val_reg;
                        out_ord_next   = hold_ord_reg;
                    end else begin
                        out_found_next = 1'b0;
                        out_row_next   = '0;
                        out_col_next   = '0;
                        out_val_next   = '0;
                        out_ord_next   = '0;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = msps_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = msps_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= msps_pkg::ST_LOAD;
            load_cnt_reg   <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        chk_reg       <= chk_next;
        rmin_reg      <= rmin_next;
        hold_row_reg  <= hold_row_next;
        hold_col_reg  <= hold_col_next;
        hold_val_reg  <= hold_val_next;
        hold_ord_reg  <= hold_ord_next;
        out_found_reg <= out_found_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_val_reg   <= out_val_next;
        out_ord_reg   <= out_ord_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = out_found_reg;
    assign m_row_index   = out_row_reg;
    assign m_col_index   = out_col_reg;
    assign m_point_value = out_val_reg;
    assign m_ordinal     = out_ord_reg;
    assign m_last_result = out_last_reg;

    // A "not found" transaction always closes the report with zero ordinal
    a_not_found_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_last_result && m_ordinal == '0)
        else $error("not-found result without last mark");

    // Reported saddle points carry an ordinal within the cap
    a_ordinal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_ordinal != '0 && m_ordinal <= OW'(msps_pkg::MAX_RESULTS))
        else $error("saddle point ordinal out of range");

    // Nothing stays held once the block is loading again
    a_hold_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == msps_pkg::ST_LOAD |-> !hold_valid_reg)
        else $error("held saddle point left behind");

    // Found count never passes the cap
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("saddle point count over cap");

endmodule

// ===== sim/tb.sv =====
module tb;

    localparam int DATA_W          = msps_pkg::DATA_W;
    localparam int IDX_W           = msps_pkg::IDX_W;
    localparam int ORD_W           = msps_pkg::ORD_W;
    localparam int MAX_RESULTS     = msps_pkg::MAX_RESULTS;
    localparam int ROWS            = msps_pkg::ROWS_DEF;
    localparam int COLS            = msps_pkg::COLS_DEF;
    localparam int CELLS           = ROWS * COLS;
    localparam int RANDOM_MATRICES = 21;
    localparam int HOLD_CYCLES     = 600;
    localparam int DRAIN_CYCLES    = 400;

    localparam logic [DATA_W-1:0] V_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] V_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // One reported saddle point, field by field as on the result channel
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic [DATA_W-1:0] point_value;
        logic [ORD_W-1:0]  ordinal;
        logic              last_result;
    } saddle_point_t;

    localparam saddle_point_t NO_SADDLE = '{
        found: 1'b0, row_index: '0, col_index: '0,
        point_value: '0, ordinal: '0, last_result: 1'b1
    };

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              has_result;
        saddle_point_t     result;
    } directed_row_t;

    typedef enum {MAT_NOISE, MAT_NARROW, MAT_PLANTED, MAT_CONSTANT} matrix_kind_t;

    // Directed matrix: MAX on the diagonal, assorted values elsewhere. Every
    // row minimum sits off the diagonal and shares its column with a MAX, so
    // the search must report "no saddle point" on the final element.
    localparam directed_row_t DIRECTED [CELLS] = '{
        '{V_MAX,         1'b0, NO_SADDLE}, '{V_MIN,         1'b0, NO_SADDLE},
        '{32'h0000_0000, 1'b0, NO_SADDLE}, '{32'hFFFF_FFFF, 1'b0, NO_SADDLE},
        '{32'h0000_0001, 1'b0, NO_SADDLE}, '{V_MAX,         1'b0, NO_SADDLE},
        '{32'h5555_5555, 1'b0, NO_SADDLE}, '{32'hAAAA_AAAA, 1'b0, NO_SADDLE},
        '{32'h7FFF_FFFE, 1'b0, NO_SADDLE}, '{32'h8000_0001, 1'b0, NO_SADDLE},
        '{V_MAX,         1'b0, NO_SADDLE}, '{32'h0F0F_F0F0, 1'b0, NO_SADDLE},
        '{32'hF0F0_0F0F, 1'b0, NO_SADDLE}, '{32'h1234_5678, 1'b0, NO_SADDLE},
        '{32'hEDCB_A987, 1'b0, NO_SADDLE}, '{V_MAX,         1'b1, NO_SADDLE}
    };

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_element_value;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_found;
    logic [IDX_W-1:0]         m_row_index;
    logic [IDX_W-1:0]         m_col_index;
    logic signed [DATA_W-1:0] m_point_value;
    logic [ORD_W-1:0]         m_ordinal;
    logic                     m_last_result;

    // Predictor state: its own copy of the matrix and the load position
    logic signed [DATA_W-1:0] matrix_cells [CELLS];
    int                       cells_loaded;
    saddle_point_t            fresh_points[$];
    saddle_point_t            pending_points[$];
    logic [DATA_W-1:0]        matrix_plan [CELLS];

    int error_count;
    int results_seen;
    bit hold_off;

    matrix_saddle_point_search #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_value(s_element_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_row_index    (m_row_index),
        .m_col_index    (m_col_index),
        .m_point_value  (m_point_value),
        .m_ordinal      (m_ordinal),
        .m_last_result  (m_last_result)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // Full search over the stored matrix; fills fresh_points
    function automatic void search_saddle_points();
        logic signed [DATA_W-1:0] row_min;
        bit                       col_ok;
        int                       found_n;
        saddle_point_t            pt;
        found_n = 0;
        for (int r = 0; r < ROWS && found_n < MAX_RESULTS; r++) begin
            row_min = matrix_cells[r*COLS];
            for (int c = 1; c < COLS; c++)
                if (matrix_cells[r*COLS+c] < row_min)
                    row_min = matrix_cells[r*COLS+c];
            for (int c = 0; c < COLS && found_n < MAX_RESULTS; c++) begin
                if (matrix_cells[r*COLS+c] == row_min) begin
                    col_ok = 1'b1;
                    for (int t = 0; t < ROWS; t++)
                        if (matrix_cells[t*COLS+c] > row_min)
                            col_ok = 1'b0;
                    if (col_ok) begin
                        found_n++;
                        pt.found       = 1'b1;
                        pt.row_index   = IDX_W'(r);
                        pt.col_index   = IDX_W'(c);
                        pt.point_value = row_min;
                        pt.ordinal     = ORD_W'(found_n);
                        pt.last_result = 1'b0;
                        fresh_points.push_back(pt);
                    end
                end
            end
        end
        if (found_n == 0) begin
            fresh_points.push_back(NO_SADDLE);
        end else begin
            pt = fresh_points.pop_back();
            pt.last_result = 1'b1;
            fresh_points.push_back(pt);
        end
    endfunction

    // Store one element; the final element of a matrix triggers the search
    function automatic void absorb_element(input logic [DATA_W-1:0] v);
        fresh_points.delete();
        matrix_cells[cells_loaded] = v;
        if (cells_loaded == CELLS - 1) begin
            cells_loaded = 0;
            search_saddle_points();
        end else begin
            cells_loaded++;
        end
    endfunction

    // Build the next random matrix into matrix_plan
    task automatic plan_matrix(input matrix_kind_t kind);
        logic [DATA_W-1:0] base;
        int                pr;
        int                pc;
        int                off;
        pr = $urandom_range(0, ROWS - 1);
        pc = $urandom_range(0, COLS - 1);
        case ($urandom_range(0, 3))
            0: base = V_MIN;
            1: base = V_MAX;
            default: base = $urandom;
        endcase
        case (kind)
            MAT_NOISE: begin
                foreach (matrix_plan[i]) matrix_plan[i] = $urandom;
            end
            MAT_NARROW: begin
                // values packed into a span of four: lots of ties
                case ($urandom_range(0, 3))
                    0: base = V_MIN;
                    1: base = V_MAX - 3;
                    2: base = -2;
                    default: base = $urandom & ~32'h3;
                endcase
                foreach (matrix_plan[i]) matrix_plan[i] = base + $urandom_range(0, 3);
            end
            MAT_PLANTED: begin
                // row pr never below the center, column pc never above it
                case ($urandom_range(0, 3))
                    0: base = V_MIN + 2;
                    1: base = V_MAX - 2;
                    default: base = $urandom_range(0, 16) - 8;
                endcase
                for (int r = 0; r < ROWS; r++) begin
                    for (int c = 0; c < COLS; c++) begin
                        if (r == pr && c == pc) off = 0;
                        else if (r == pr) off = $urandom_range(0, 2);
                        else if (c == pc) off = -$urandom_range(0, 2);
                        else off = $urandom_range(0, 4) - 2;
                        matrix_plan[r*COLS+c] = base + off;
                    end
                end
            end
            default: begin
                // constant matrix: every cell is a saddle point
                foreach (matrix_plan[i]) matrix_plan[i] = base;
            end
        endcase
    endtask

    // Offer one element, called at a falling edge; returns at a falling edge
    task automatic offer_element(input logic [DATA_W-1:0] v, input int gap,
                                 input logic has_result, input saddle_point_t typed);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_element_value <= v;
        do @(posedge aclk); while (!s_ready);
        absorb_element(v);
        if (has_result)
            pending_points.push_back(typed);
        else
            foreach (fresh_points[i]) pending_points.push_back(fresh_points[i]);
        @(negedge aclk);
    endtask

    // Result checker: compare each accepted transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        saddle_point_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end else begin
                want = pending_points.pop_front();
                check_field("found",       DATA_W'(m_found),       DATA_W'(want.found));
                check_field("row_index",   DATA_W'(m_row_index),   DATA_W'(want.row_index));
                check_field("col_index",   DATA_W'(m_col_index),   DATA_W'(want.col_index));
                check_field("point_value", m_point_value,          want.point_value);
                check_field("ordinal",     DATA_W'(m_ordinal),     DATA_W'(want.ordinal));
                check_field("last_result", DATA_W'(m_last_result), DATA_W'(want.last_result));
            end
        end
    end

    // Result side: random stalls, calm stretches, and the long hold-off
    initial begin : result_sink
        int gap;
        bit calm;
        m_ready = 1'b0;
        calm    = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            while (hold_off) begin
                m_ready <= 1'b0;
                @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Long back-pressure window while the sender keeps offering elements
    initial begin : backpressure
        hold_off = 1'b0;
        wait (results_seen >= 6);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin : watchdog
        #2_000_000;
        $display("matrix_saddle_point_search: mismatch");
        $finish;
    end

    // Stimulus: directed matrix, then random matrices, then drain
    initial begin : stimulus
        int           gap;
        bit           steady;
        matrix_kind_t kind;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_element_value = '0;
        cells_loaded    = 0;
        error_count     = 0;
        results_seen    = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < CELLS; i++)
            offer_element(DIRECTED[i].value, $urandom_range(0, 5),
                          DIRECTED[i].has_result, DIRECTED[i].result);

        for (int m = 0; m < RANDOM_MATRICES; m++) begin
            case ($urandom_range(0, 9))
                0, 1:    kind = MAT_NOISE;
                2, 3, 4: kind = MAT_NARROW;
                9:       kind = MAT_CONSTANT;
                default: kind = MAT_PLANTED;
            endcase
            if (m == 0) kind = MAT_CONSTANT;
            plan_matrix(kind);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < CELLS; i++) begin
                gap = steady ? 0 : $urandom_range(0, 5);
                offer_element(matrix_plan[i], gap, 1'b0, NO_SADDLE);
            end
        end
        s_valid <= 1'b0;

        while (pending_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("matrix_saddle_point_search: match");
        else
            $display("matrix_saddle_point_search: mismatch");
        $finish;
    end

endmodule
